@@ design/mvf_pkg.sv @@
// Shared types and constants for the multiscale valley finder.
// No dependencies; imported by the controller, datapath and top level.
package mvf_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int RES_W       = $clog2(MAX_RESULTS) + 1;
    localparam int GRP_SIZE    = 8;
    localparam int NUM_GRP     = (MAX_SAMPLES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W       = $clog2(GRP_SIZE + 1);

    typedef struct packed {
        logic load;     // sample request accepted this cycle
        logic setup;    // prime the shifted sample copies
        logic scan;     // evaluate one scale
        logic match;    // build the qualifying-position vector
        logic emit;     // step the result scan
    } mvf_cmd_t;

    typedef struct packed {
        logic no_scales;    // window too short for any scale
        logic scan_last;    // current scale is the final one
        logic pipe_empty;   // count pipeline drained
        logic emit_finish;  // final result of the window loaded
    } mvf_status_t;

endpackage

@@ design/mvf_ctrl.sv @@
// Sequencing state machine for the valley finder.
// Depends on mvf_pkg for the command and status structs.
module mvf_ctrl
    import mvf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  mvf_status_t status,
    output mvf_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_MATCH,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_LOAD);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid && s_tlast)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // no_scales comes from the window size registered with the last sample
                if (status.no_scales)
                    state_next = ST_MATCH;
                else
                begin
                    cmd.scan = 1'b1;
                    if (status.scan_last)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                    state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_finish)
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

endmodule

@@ design/mvf_datapath.sv @@
// Sample lanes, per-scale valley counting pipeline, best-scale tracking
// and result scan. Depends on mvf_pkg; driven by mvf_ctrl commands.
module mvf_datapath
    import mvf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mvf_cmd_t          cmd,
    output mvf_status_t       status,
    input  logic [7:0]        sample,
    input  logic              last_sample,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [IDX_W-1:0]  valley_index,
    output logic              found,
    output logic              last_result
);

    // sample lanes: center, left copy (i-k) and right copy (i+k)
    logic [7:0] center_reg [MAX_SAMPLES];
    logic [7:0] left_reg   [MAX_SAMPLES];
    logic [7:0] right_reg  [MAX_SAMPLES];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] k_reg;
    logic [CNT_W-1:0] half;

    // per-lane: still a valley at every scale so far, and how many scales
    logic             alive_reg [MAX_SAMPLES];
    logic [IDX_W-1:0] run_reg   [MAX_SAMPLES];

    logic [MAX_SAMPLES-1:0] valley_vec;

    // counting pipeline
    logic                   st1_valid_reg;
    logic                   st1_first_reg;
    logic [IDX_W-1:0]       st1_k_reg;
    logic [MAX_SAMPLES-1:0] st1_vec_reg;
    logic                   st2_valid_reg;
    logic                   st2_first_reg;
    logic [IDX_W-1:0]       st2_k_reg;
    logic [GRP_W-1:0]       grp_cnt_reg [NUM_GRP];
    logic [GRP_W-1:0]       grp_cnt_next [NUM_GRP];
    logic [CNT_W-1:0]       total;

    logic [IDX_W-1:0] best_scale_reg;
    logic [CNT_W-1:0] best_total_reg;

    // result scan
    logic [MAX_SAMPLES-1:0] match_reg;
    logic [MAX_SAMPLES-1:0] match_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [RES_W-1:0]       emit_cnt_reg;
    logic                   slot_free;
    logic                   emit_empty;
    logic                   emit_hit_last;
    logic                   emit_go;

    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_found_reg;
    logic             out_last_reg;

    assign half = n_reg >> 1;

    // loading
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            n_reg     <= '0;
        end
        else if (cmd.load)
        begin
            if (last_sample)
            begin
                count_reg <= '0;
                n_reg     <= (count_reg < CNT_W'(MAX_SAMPLES)) ? count_reg + 1'b1 : count_reg;
            end
            else if (count_reg < CNT_W'(MAX_SAMPLES))
                count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg < CNT_W'(MAX_SAMPLES))
            center_reg[count_reg[IDX_W-1:0]] <= sample;
    end

    // lane compares for the current scale
    always_comb
    begin
        for (int i = 0; i < MAX_SAMPLES; i++)
        begin
            valley_vec[i] = (CNT_W'(i) >= CNT_W'(k_reg))
                         && ((CNT_W'(i) + CNT_W'(k_reg)) < n_reg)
                         && (center_reg[i] < left_reg[i])
                         && (center_reg[i] < right_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            for (int i = 0; i < MAX_SAMPLES; i++)
            begin
                left_reg[i]  <= (i > 0) ? center_reg[(i > 0) ? i - 1 : 0] : center_reg[i];
                right_reg[i] <= (i < MAX_SAMPLES - 1)
                              ? center_reg[(i < MAX_SAMPLES - 1) ? i + 1 : i] : center_reg[i];
                run_reg[i]   <= '0;
            end
        end
        else if (cmd.scan)
        begin
            for (int i = 0; i < MAX_SAMPLES; i++)
            begin
                left_reg[i]  <= (i > 0) ? left_reg[(i > 0) ? i - 1 : 0] : left_reg[i];
                right_reg[i] <= (i < MAX_SAMPLES - 1)
                              ? right_reg[(i < MAX_SAMPLES - 1) ? i + 1 : i] : right_reg[i];
                if (alive_reg[i] && valley_vec[i])
                    run_reg[i] <= k_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SAMPLES; i++)
                alive_reg[i] <= 1'b0;
            k_reg <= '0;
        end
        else if (cmd.setup)
        begin
            for (int i = 0; i < MAX_SAMPLES; i++)
                alive_reg[i] <= 1'b1;
            k_reg <= IDX_W'(1);
        end
        else if (cmd.scan)
        begin
            for (int i = 0; i < MAX_SAMPLES; i++)
                if (!valley_vec[i])
                    alive_reg[i] <= 1'b0;
            k_reg <= k_reg + 1'b1;
        end
    end

    // popcount: groups of eight, then the group sum
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_cnt_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
                if (g * GRP_SIZE + j < MAX_SAMPLES)
                    grp_cnt_next[g] = grp_cnt_next[g]
                                    + GRP_W'(st1_vec_reg[(g * GRP_SIZE + j) % MAX_SAMPLES]);
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NUM_GRP; g++)
            total = total + CNT_W'(grp_cnt_reg[g]);
    end

    always_ff @(posedge clk)
    begin
        st1_vec_reg   <= valley_vec;
        st1_k_reg     <= k_reg;
        st1_first_reg <= (k_reg == IDX_W'(1));
        st2_k_reg     <= st1_k_reg;
        st2_first_reg <= st1_first_reg;
        for (int g = 0; g < NUM_GRP; g++)
            grp_cnt_reg[g] <= grp_cnt_next[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg  <= 1'b0;
            st2_valid_reg  <= 1'b0;
            best_scale_reg <= '0;
            best_total_reg <= '0;
        end
        else
        begin
            st1_valid_reg <= cmd.scan;
            st2_valid_reg <= st1_valid_reg;
            if (cmd.setup)
            begin
                best_scale_reg <= '0;
                best_total_reg <= '0;
            end
            else if (st2_valid_reg && (st2_first_reg || total > best_total_reg))
            begin
                // smallest scale wins ties: only a strictly larger total replaces
                best_scale_reg <= st2_k_reg;
                best_total_reg <= total;
            end
        end
    end

    // a position qualifies when it stayed a valley through every scale up to S
    always_comb
    begin
        for (int i = 0; i < MAX_SAMPLES; i++)
            match_next[i] = (best_scale_reg != '0) && (run_reg[i] >= best_scale_reg);
    end

    assign slot_free     = !out_valid_reg || m_tready;
    assign emit_go       = cmd.emit && slot_free;
    assign emit_empty    = (match_reg == '0) && (emit_cnt_reg == '0);
    assign emit_hit_last = ((match_reg >> 1) == '0)
                        || (emit_cnt_reg == RES_W'(MAX_RESULTS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            match_reg <= match_next;
            idx_reg   <= '0;
        end
        else if (emit_go)
        begin
            match_reg <= match_reg >> 1;
            idx_reg   <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.match)
                emit_cnt_reg <= '0;
            else if (emit_go && match_reg[0])
                emit_cnt_reg <= emit_cnt_reg + 1'b1;

            if (emit_go && (emit_empty || match_reg[0]))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go && emit_empty)
        begin
            out_idx_reg   <= '0;
            out_found_reg <= 1'b0;
            out_last_reg  <= 1'b1;
        end
        else if (emit_go && match_reg[0])
        begin
            out_idx_reg   <= idx_reg;
            out_found_reg <= 1'b1;
            out_last_reg  <= emit_hit_last;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign valley_index = out_idx_reg;
    assign found        = out_found_reg;
    assign last_result  = out_last_reg;

    assign status.no_scales   = (half == '0);
    assign status.scan_last   = (CNT_W'(k_reg) >= half);
    assign status.pipe_empty  = !st1_valid_reg && !st2_valid_reg;
    assign status.emit_finish = emit_go && (emit_empty || (match_reg[0] && emit_hit_last));

    // checks
    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.match |-> CNT_W'(best_scale_reg) <= half)
        else $error("best scale beyond half the window");

    a_scale_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        st1_valid_reg |-> (st1_k_reg != '0) && (CNT_W'(st1_k_reg) <= half))
        else $error("scale issued outside 1..n/2");

    a_nofound_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_last_reg && (out_idx_reg == '0))
        else $error("no-valley result must be the final one");

    a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= RES_W'(MAX_RESULTS))
        else $error("result count over limit");

    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.match |-> status.pipe_empty)
        else $error("match built before counting pipeline drained");

endmodule

@@ design/multiscale_valley_finder_unit.sv @@
// Order: the samples load, setup primes the shifted copies, one scale pass runs per
// scale 1..n/2 (none when n < 2), the count pipeline drains, match builds the vector,
// then the result scan steps through window positions up to the last hit or the 32nd
// result, each step held while the output register waits on m_tready. Throughput:
// one window at a time; all lanes compare in parallel, one scale per cycle. Reset (rst_n,
// async, low) empties the window and returns to sample loading; samples are not cleared.
module multiscale_valley_finder_unit
    import mvf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] sample
    input  logic       s_tlast,   // last_sample
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [5:0] valley_index, [6] found, [7] zero
    output logic       m_tlast    // last_result
);

    mvf_cmd_t         cmd;
    mvf_status_t      status;
    logic [IDX_W-1:0] valley_index;
    logic             found;

    mvf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mvf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (s_tdata),
        .last_sample  (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .valley_index (valley_index),
        .found        (found),
        .last_result  (m_tlast)
    );

    assign m_tdata = {1'b0, found, valley_index};

endmodule
